// File: src/mtb_pkg.sv
// Shared types, codes and default sizes for the multi-timer bank.
package mtb_pkg;

  // Default sizes handed to the top level parameters.
  localparam int TIMER_COUNT_DEF = 16;
  localparam int TICK_WIDTH_DEF  = 32;

  // Widest timer index or queue position carried between modules (up to 256 timers).
  localparam int QIDX_W = 8;

  // Request codes on req_type.
  localparam logic [2:0] REQ_RUN       = 3'd0;
  localparam logic [2:0] REQ_START_ONE = 3'd1;
  localparam logic [2:0] REQ_START_PER = 3'd2;
  localparam logic [2:0] REQ_STOP      = 3'd3;
  localparam logic [2:0] REQ_PAUSE     = 3'd4;
  localparam logic [2:0] REQ_RESUME    = 3'd5;
  localparam logic [2:0] REQ_QUERY     = 3'd6;

  // Operations of the shared tick adder.
  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_ADDS = 2'd1,
    ALU_SUB  = 2'd2,
    ALU_SUBS = 2'd3
  } alu_op_t;

  // Operations on the queue ranks.
  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_REMOVE = 2'd1,
    Q_INSERT = 2'd2
  } q_op_t;

  // One command to the queue: operation, timer and insert position.
  typedef struct packed {
    q_op_t             op;
    logic [QIDX_W-1:0] idx;
    logic [QIDX_W-1:0] pos;
  } q_cmd_t;

endpackage

// File: src/mtb_alu.sv
// Shared tick-width add/subtract unit with optional saturation.
module mtb_alu import mtb_pkg::*; #(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  alu_op_t               op,
  input  logic [TICK_WIDTH-1:0] a,
  input  logic [TICK_WIDTH-1:0] b,
  output logic [TICK_WIDTH-1:0] y,
  output logic                  flag
);

  logic [TICK_WIDTH:0] sum;
  logic [TICK_WIDTH:0] diff;

  // One carry chain each way; the flag is the carry on adds and the borrow on subtracts.
  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    case (op)
      ALU_ADD: begin
        y    = sum[TICK_WIDTH-1:0];
        flag = sum[TICK_WIDTH];
      end
      ALU_ADDS: begin
        y    = sum[TICK_WIDTH] ? '1 : sum[TICK_WIDTH-1:0];
        flag = sum[TICK_WIDTH];
      end
      ALU_SUB: begin
        y    = diff[TICK_WIDTH-1:0];
        flag = diff[TICK_WIDTH];
      end
      ALU_SUBS: begin
        y    = diff[TICK_WIDTH] ? '0 : diff[TICK_WIDTH-1:0];
        flag = diff[TICK_WIDTH];
      end
      default: begin
        y    = '0;
        flag = 1'b0;
      end
    endcase
  end

endmodule

// File: src/mtb_queue.sv
// Queue membership and ranks of all timers, with lookup by rank.
module mtb_queue import mtb_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  q_cmd_t                                cmd,
  input  logic [$clog2(TIMER_COUNT+1)-1:0]      find_pos,
  input  logic [((TIMER_COUNT>1)?$clog2(TIMER_COUNT):1)-1:0] rd_idx,
  output logic                                  found,
  output logic [((TIMER_COUNT>1)?$clog2(TIMER_COUNT):1)-1:0] found_idx,
  output logic                                  rd_active
);

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int PW = $clog2(TIMER_COUNT + 1);

  logic [TIMER_COUNT-1:0] active;
  logic [IW-1:0]          rank [TIMER_COUNT];
  logic [IW-1:0]          tgt;
  logic [IW-1:0]          pos;
  logic [IW-1:0]          tgt_rank;

  assign tgt       = cmd.idx[IW-1:0];
  assign pos       = cmd.pos[IW-1:0];
  assign tgt_rank  = rank[tgt];
  assign rd_active = active[rd_idx];

  // Find the queued timer holding the requested position.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
      if (active[i] && (PW'(rank[i]) == find_pos)) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  // Every lane closes or opens the gap on its own when a timer leaves or enters.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        rank[i] <= '0;
      end
    end else begin
      case (cmd.op)
        Q_REMOVE: begin
          if (active[tgt]) begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
              if (active[i] && (rank[i] > tgt_rank)) begin
                rank[i] <= rank[i] - 1'b1;
              end
            end
            active[tgt] <= 1'b0;
            rank[tgt]   <= '0;
          end
        end
        Q_INSERT: begin
          for (int i = 0; i < TIMER_COUNT; i++) begin
            if (active[i] && (rank[i] >= pos)) begin
              rank[i] <= rank[i] + 1'b1;
            end
          end
          active[tgt] <= 1'b1;
          rank[tgt]   <= pos;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/multi_timer_bank.sv
// Top level of the multi-timer bank: sequencer, timer words and result registers.
//
//  channel  | handshake          | word
//  request  | start / busy       | req_type, timer_id, duration, now_count
//  result   | done (one cycle)   | fired, fired_id, is_running, is_paused,
//           |                    | remaining, start_length, elapsed
//
// A request is taken when start is high and busy is low; busy then stays high until the
// result is shown. A queue walk steps through the positions in order, comparing expiries
// on the way, and may run on to the end of the queue; a run can walk three times. The
// walks go through the single shared tick adder.
// done is high for exactly one cycle; the receiver cannot stall it.
// Synchronous reset stops all timers and clears the tick count and the source count.
module multi_timer_bank import mtb_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [3:0]  timer_id,
  input  logic [31:0] duration,
  input  logic [31:0] now_count,
  output logic        done,
  output logic        fired,
  output logic [3:0]  fired_id,
  output logic        is_running,
  output logic        is_paused,
  output logic [31:0] remaining,
  output logic [31:0] start_length,
  output logic [31:0] elapsed
);

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int PW = $clog2(TIMER_COUNT + 1);
  localparam int TW = TICK_WIDTH;
  localparam logic [8:0] TC9 = 9'(TIMER_COUNT);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_PEND      = 15'b000000000000010,
    S_DECODE    = 15'b000000000000100,
    S_PAUSE2    = 15'b000000000001000,
    S_REMOVE    = 15'b000000000010000,
    S_SETEXP    = 15'b000000000100000,
    S_ADD_FIND  = 15'b000000001000000,
    S_ADD_CMP   = 15'b000000010000000,
    S_INSERT    = 15'b000000100000000,
    S_MARK_FIND = 15'b000001000000000,
    S_MARK_CMP  = 15'b000010000000000,
    S_FIRE_FIND = 15'b000100000000000,
    S_OUT1      = 15'b001000000000000,
    S_OUT2      = 15'b010000000000000,
    S_OUT3      = 15'b100000000000000
  } state_t;

  state_t state;

  // Timer words and flags.
  logic [TW-1:0]          exp_mem [TIMER_COUNT];
  logic [TW-1:0]          len_mem [TIMER_COUNT];
  logic [TW-1:0]          pl_mem  [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] pause_f;
  logic [TIMER_COUNT-1:0] due_f;
  logic [TIMER_COUNT-1:0] reload_f;
  logic [TW-1:0]          now_ticks;
  logic [31:0]            last_source;

  // Request and working registers.
  logic [2:0]    req_q;
  logic [3:0]    id_q;
  logic [31:0]   dur_q;
  logic [31:0]   nowc_q;
  logic [TW-1:0] pend_q;
  logic [TW-1:0] delta_q;
  logic [TW-1:0] prev_q;
  logic [TW-1:0] tmp_q;
  logic [TW-1:0] tmp2_q;
  logic [TW-1:0] rem_q;
  logic [IW-1:0] ptr;
  logic [IW-1:0] cur;
  logic [IW-1:0] fid_q;
  logic [PW-1:0] p;
  logic          readd;
  logic          fired_q;

  // Shared unit and queue connections.
  alu_op_t       alu_op;
  logic [TW-1:0] alu_a;
  logic [TW-1:0] alu_b;
  logic [TW-1:0] alu_y;
  logic          alu_flag;
  q_cmd_t        qcmd;
  logic          q_found;
  logic [IW-1:0] q_found_idx;
  logic          q_rd_active;
  logic [IW-1:0] rd_idx;

  // Derived values.
  logic          ok;
  logic [31:0]   pend32;
  logic [63:0]   pend64;
  logic [63:0]   dur64;
  logic [TW-1:0] dur_tw;
  logic [TW-1:0] exp_rd;
  logic [TW-1:0] len_rd;
  logic [TW-1:0] pl_rd;
  logic          pause_rd;
  logic          due_rd;
  logic          reload_rd;
  logic [63:0]   rem64;
  logic [63:0]   len64;
  logic [63:0]   ela64;
  logic [7:0]    fid8;

  assign busy   = (state != S_IDLE);
  assign ok     = ({5'b0, id_q} < TC9);
  assign pend32 = nowc_q - last_source;
  assign pend64 = 64'(pend32);
  assign dur64  = 64'(dur_q);
  assign dur_tw = dur64[TW-1:0];

  // One read port on the timer words: the rank lookup during walks, the addressed timer
  // while the result is built, the working pointer otherwise.
  always_comb begin
    case (state)
      S_ADD_FIND, S_MARK_FIND, S_FIRE_FIND: rd_idx = q_found_idx;
      S_OUT1, S_OUT2, S_OUT3:               rd_idx = IW'(id_q);
      default:                              rd_idx = ptr;
    endcase
  end

  assign exp_rd    = exp_mem[rd_idx];
  assign len_rd    = len_mem[rd_idx];
  assign pl_rd     = pl_mem[rd_idx];
  assign pause_rd  = pause_f[rd_idx];
  assign due_rd    = due_f[rd_idx];
  assign reload_rd = reload_f[rd_idx];

  // Operand selection for the shared adder.
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_DECODE: begin
        case (req_q)
          REQ_RUN: begin
            alu_a = now_ticks;
            alu_b = pend_q;
          end
          REQ_START_ONE, REQ_START_PER: begin
            alu_op = ALU_ADDS;
            alu_a  = dur_tw;
            alu_b  = pend_q;
          end
          REQ_PAUSE: begin
            alu_op = ALU_SUB;
            alu_a  = exp_rd;
            alu_b  = now_ticks;
          end
          REQ_RESUME: begin
            alu_op = ALU_ADDS;
            alu_a  = pl_rd;
            alu_b  = pend_q;
          end
          default: begin
          end
        endcase
      end
      S_PAUSE2, S_OUT2: begin
        alu_op = ALU_SUBS;
        alu_a  = (state == S_PAUSE2) ? tmp_q : tmp2_q;
        alu_b  = pend_q;
      end
      S_SETEXP: begin
        alu_a = now_ticks;
        alu_b = tmp_q;
      end
      S_ADD_FIND, S_OUT1: begin
        alu_op = ALU_SUB;
        alu_a  = exp_rd;
        alu_b  = now_ticks;
      end
      S_ADD_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = tmp_q;
        alu_b  = tmp2_q;
      end
      S_MARK_FIND: begin
        alu_op = ALU_SUB;
        alu_a  = exp_rd;
        alu_b  = prev_q;
      end
      S_MARK_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = delta_q;
        alu_b  = tmp2_q;
      end
      S_OUT3: begin
        alu_op = ALU_SUB;
        alu_a  = len_rd;
        alu_b  = rem_q;
      end
      default: begin
      end
    endcase
  end

  // Queue commands come from the remove and insert steps.
  always_comb begin
    qcmd.op  = Q_NONE;
    qcmd.idx = QIDX_W'(cur);
    qcmd.pos = QIDX_W'(p);
    case (state)
      S_REMOVE: qcmd.op = Q_REMOVE;
      S_INSERT: qcmd.op = Q_INSERT;
      default:  qcmd.op = Q_NONE;
    endcase
  end

  mtb_alu #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .y    (alu_y),
    .flag (alu_flag)
  );

  mtb_queue #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (qcmd),
    .find_pos  (p),
    .rd_idx    (rd_idx),
    .found     (q_found),
    .found_idx (q_found_idx),
    .rd_active (q_rd_active)
  );

  assign rem64 = 64'(rem_q);
  assign len64 = 64'(len_rd);
  assign ela64 = 64'(alu_y);
  assign fid8  = 8'(fid_q);

  // Timer words carry no reset: each is written before any read that reaches a result.
  always_ff @(posedge clk) begin
    case (state)
      S_PAUSE2: pl_mem[ptr] <= alu_y;
      S_SETEXP: exp_mem[cur] <= alu_y;
      S_REMOVE: begin
        if ((req_q == REQ_START_ONE) || (req_q == REQ_START_PER)) begin
          len_mem[cur] <= dur_tw;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      pause_f     <= '0;
      due_f       <= '0;
      reload_f    <= '0;
      now_ticks   <= '0;
      last_source <= '0;
      fired       <= 1'b0;
      fired_id    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q   <= req_type;
            id_q    <= timer_id;
            dur_q   <= duration;
            nowc_q  <= now_count;
            ptr     <= IW'(timer_id);
            fired_q <= 1'b0;
            fid_q   <= '0;
            state   <= S_PEND;
          end
        end
        S_PEND: begin
          pend_q <= pend64[TW-1:0];
          state  <= S_DECODE;
        end
        S_DECODE: begin
          cur   <= ptr;
          state <= S_OUT1;
          case (req_q)
            REQ_RUN: begin
              now_ticks   <= alu_y;
              prev_q      <= now_ticks;
              delta_q     <= pend_q;
              last_source <= nowc_q;
              pend_q      <= '0;
              p           <= '0;
              state       <= S_MARK_FIND;
            end
            REQ_START_ONE, REQ_START_PER: begin
              if (ok) begin
                tmp_q <= alu_y;
                readd <= 1'b1;
                state <= S_REMOVE;
              end
            end
            REQ_STOP: begin
              if (ok) begin
                readd <= 1'b0;
                state <= S_REMOVE;
              end
            end
            REQ_PAUSE: begin
              if (ok && q_rd_active && !pause_rd) begin
                tmp_q <= alu_y;
                state <= S_PAUSE2;
              end
            end
            REQ_RESUME: begin
              if (ok && q_rd_active && pause_rd) begin
                tmp_q <= alu_y;
                readd <= 1'b1;
                state <= S_REMOVE;
              end
            end
            default: begin
            end
          endcase
        end
        S_PAUSE2: begin
          pause_f[ptr] <= 1'b1;
          state        <= S_OUT1;
        end
        S_REMOVE: begin
          case (req_q)
            REQ_START_ONE, REQ_START_PER: begin
              reload_f[cur] <= (req_q == REQ_START_PER);
              pause_f[cur]  <= 1'b0;
              due_f[cur]    <= 1'b0;
            end
            REQ_RESUME: pause_f[cur] <= 1'b0;
            REQ_RUN: begin
              if (readd) begin
                due_f[cur] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
          state <= readd ? S_SETEXP : S_OUT1;
        end
        S_SETEXP: begin
          // The distance to expiry of the timer being placed equals tmp_q itself.
          p     <= '0;
          state <= S_ADD_FIND;
        end
        S_ADD_FIND: begin
          if (!q_found) begin
            state <= S_INSERT;
          end else if (pause_rd || due_rd) begin
            p <= p + 1'b1;
          end else begin
            tmp2_q <= alu_y;
            state  <= S_ADD_CMP;
          end
        end
        S_ADD_CMP: begin
          // A borrow means the queued timer expires strictly later.
          if (alu_flag) begin
            state <= S_INSERT;
          end else begin
            p     <= p + 1'b1;
            state <= S_ADD_FIND;
          end
        end
        S_INSERT: state <= S_OUT1;
        S_MARK_FIND: begin
          if (!q_found) begin
            p     <= '0;
            state <= S_FIRE_FIND;
          end else if (pause_rd) begin
            p <= p + 1'b1;
          end else begin
            tmp2_q <= alu_y;
            ptr    <= q_found_idx;
            state  <= S_MARK_CMP;
          end
        end
        S_MARK_CMP: begin
          // The walk stops at the first unpaused timer that is still not due.
          if (!alu_flag) begin
            due_f[ptr] <= 1'b1;
            p          <= p + 1'b1;
            state      <= S_MARK_FIND;
          end else if (due_f[ptr]) begin
            p     <= p + 1'b1;
            state <= S_MARK_FIND;
          end else begin
            p     <= '0;
            state <= S_FIRE_FIND;
          end
        end
        S_FIRE_FIND: begin
          if (!q_found) begin
            state <= S_OUT1;
          end else if (!pause_rd && due_rd) begin
            fired_q <= 1'b1;
            fid_q   <= q_found_idx;
            cur     <= q_found_idx;
            readd   <= reload_rd;
            tmp_q   <= len_rd;
            state   <= S_REMOVE;
          end else begin
            p <= p + 1'b1;
          end
        end
        S_OUT1: begin
          tmp2_q <= alu_y;
          state  <= S_OUT2;
        end
        S_OUT2: begin
          rem_q <= pause_rd ? pl_rd : alu_y;
          state <= S_OUT3;
        end
        S_OUT3: begin
          done     <= 1'b1;
          fired    <= fired_q;
          fired_id <= fired_q ? fid8[3:0] : 4'd0;
          if (ok && q_rd_active) begin
            is_running   <= 1'b1;
            is_paused    <= pause_rd;
            remaining    <= rem64[31:0];
            start_length <= len64[31:0];
            elapsed      <= ela64[31:0];
          end else begin
            is_running   <= 1'b0;
            is_paused    <= 1'b0;
            remaining    <= '0;
            start_length <= '0;
            elapsed      <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
